>>> hdl/utw8_pkg.sv
// utw8_pkg: shared types, constants and byte-encoding functions for the
// utf-16 to wtf-8 encoder
// no dependencies
package utw8_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int JOB_BYTES   = 6;
    localparam int JOB_CW      = $clog2(JOB_BYTES + 1);

    localparam logic [5:0]  HIGH_PREFIX = 6'b110110;
    localparam logic [5:0]  LOW_PREFIX  = 6'b110111;
    localparam logic [10:0] PLANE_OFFSET = 11'h040;

    typedef enum logic [2:0] {
        KIND_ASCII = 3'd0,
        KIND_TWO   = 3'd1,
        KIND_THREE = 3'd2,
        KIND_HIGH  = 3'd3,
        KIND_LOW   = 3'd4
    } kind_t;

    typedef struct packed {
        logic [JOB_CW-1:0]            count;
        logic [JOB_BYTES-1:0][7:0]    bytes;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic kind_t unit_kind(input logic [15:0] u);
        kind_t k;
        if (u[15:10] == HIGH_PREFIX) begin
            k = KIND_HIGH;
        end else if (u[15:10] == LOW_PREFIX) begin
            k = KIND_LOW;
        end else if (u[15:7] == 9'd0) begin
            k = KIND_ASCII;
        end else if (u[15:11] == 5'd0) begin
            k = KIND_TWO;
        end else begin
            k = KIND_THREE;
        end
        return k;
    endfunction

    // first byte in element 0
    function automatic logic [2:0][7:0] enc_three(input logic [15:0] u);
        logic [2:0][7:0] b;
        b[0] = {4'b1110, u[15:12]};
        b[1] = {2'b10, u[11:6]};
        b[2] = {2'b10, u[5:0]};
        return b;
    endfunction

endpackage

>>> hdl/utw8_front.sv
// utw8_front: accepts code units, keeps the held high surrogate and turns each
// unit into a job of up to six bytes
// depends on utw8_pkg
module utw8_front import utw8_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [15:0]   s_unit,
    input  logic          s_end_of_string,
    input  logic          s_valid,
    output logic          s_ready,
    input  queue_status_t q_status,
    output logic          push,
    output job_t          push_job
);

    logic [9:0]       held_high_reg;
    logic [9:0]       held_high_next;
    logic             held_valid_reg;
    logic             held_valid_next;
    logic             accept;
    kind_t            kind;
    logic             pair;
    logic             flush;
    logic [2:0][7:0]  sec;
    logic [JOB_CW-1:0] sec_n;
    logic [10:0]      plane;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign kind    = unit_kind(s_unit);
    assign pair    = held_valid_reg && (kind == KIND_LOW);
    assign flush   = held_valid_reg && !pair;
    assign plane   = {1'b0, held_high_reg} + PLANE_OFFSET;

    always_comb begin
        sec   = enc_three(s_unit);
        sec_n = JOB_CW'(0);
        unique case (kind)
            KIND_ASCII: begin
                sec[0] = s_unit[7:0];
                sec_n  = JOB_CW'(1);
            end
            KIND_TWO: begin
                sec[0] = {3'b110, s_unit[10:6]};
                sec[1] = {2'b10, s_unit[5:0]};
                sec_n  = JOB_CW'(2);
            end
            KIND_THREE, KIND_LOW: begin
                sec_n = JOB_CW'(3);
            end
            KIND_HIGH: begin
                sec_n = s_end_of_string ? JOB_CW'(3) : JOB_CW'(0);
            end
            default: begin
                sec_n = JOB_CW'(0);
            end
        endcase
    end

    always_comb begin
        push_job = '0;
        if (pair) begin
            push_job.bytes[0] = {5'b11110, plane[10:8]};
            push_job.bytes[1] = {2'b10, plane[7:2]};
            push_job.bytes[2] = {2'b10, plane[1:0], s_unit[9:6]};
            push_job.bytes[3] = {2'b10, s_unit[5:0]};
            push_job.count    = JOB_CW'(4);
        end else if (flush) begin
            push_job.bytes[2:0] = enc_three({HIGH_PREFIX, held_high_reg});
            push_job.bytes[5:3] = sec;
            push_job.count      = JOB_CW'(3) + sec_n;
        end else begin
            push_job.bytes[2:0] = sec;
            push_job.count      = sec_n;
        end
    end

    assign push = accept && (push_job.count != JOB_CW'(0));

    always_comb begin
        held_high_next  = held_high_reg;
        held_valid_next = held_valid_reg;
        if (accept) begin
            if ((kind == KIND_HIGH) && !s_end_of_string) begin
                held_high_next  = s_unit[9:0];
                held_valid_next = 1'b1;
            end else begin
                held_high_next  = 10'd0;
                held_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_high_reg  <= 10'd0;
            held_valid_reg <= 1'b0;
        end else begin
            held_high_reg  <= held_high_next;
            held_valid_reg <= held_valid_next;
        end
    end

endmodule

>>> hdl/utw8_queue.sv
// utw8_queue: short job queue between the front and back parts
// depends on utw8_pkg
module utw8_queue import utw8_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  job_t          push_job,
    input  logic          pop,
    output job_t          head_job,
    output queue_status_t q_status
);

    job_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;

    assign head_job       = mem_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == QUEUE_CW'(0));

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + QUEUE_CW'(1);
            2'b01:   count_next = count_reg - QUEUE_CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/utw8_back.sv
// utw8_back: walks the head job byte by byte into the output register
// depends on utw8_pkg
module utw8_back import utw8_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  job_t          head_job,
    input  queue_status_t q_status,
    output logic          pop,
    output logic [7:0]    m_out_byte,
    output logic          m_last_of_run,
    output logic          m_valid,
    input  logic          m_ready
);

    logic [JOB_CW-1:0] idx_reg;
    logic [JOB_CW-1:0] idx_next;
    logic              valid_reg;
    logic              valid_next;
    logic [7:0]        byte_reg;
    logic              last_reg;
    logic              load;
    logic              at_end;

    assign load   = !q_status.empty && (!valid_reg || m_ready);
    assign at_end = (idx_reg == head_job.count - JOB_CW'(1));
    assign pop    = load && at_end;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = at_end ? JOB_CW'(0) : idx_reg + JOB_CW'(1);
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= head_job.bytes[idx_reg];
            last_reg <= at_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign m_out_byte    = byte_reg;
    assign m_last_of_run = last_reg;
    assign m_valid       = valid_reg;

endmodule

>>> hdl/utf16_to_wtf8_encoder.sv
// utf16_to_wtf8_encoder: top level of the utf-16 to wtf-8 encoder
// depends on utw8_pkg, utw8_front, utw8_queue, utw8_back
//
// Takes one utf-16 code unit per transaction (tlast marks the end of the
// string) and gives wtf-8 bytes, one per transaction, with tlast on the final
// byte caused by each unit. A high surrogate followed by a low one yields a
// 4-byte sequence; an unpaired surrogate yields its own 3-byte sequence, and a
// high surrogate at the end of the string is flushed at once. A high surrogate
// that is held yields nothing until the next unit. The result side moves one
// byte per cycle while a job waits and the output is not stalled. A unit
// gives 1 to 3 bytes if plain, 4 for a surrogate pair, and 3 more when a held
// surrogate is flushed ahead of the unit, so up to 6. A four-entry queue of
// decoded units sits between input and output, so the input takes a unit
// every cycle while the queue has room.
module utf16_to_wtf8_encoder import utw8_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] s_axis_tdata,  // [15:0] utf-16 unit
    input  logic        s_axis_tlast,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);

    queue_status_t q_status;
    logic          push;
    job_t          push_job;
    logic          pop;
    job_t          head_job;
    logic          out_first_reg;

    utw8_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_unit          (s_axis_tdata),
        .s_end_of_string (s_axis_tlast),
        .s_valid         (s_axis_tvalid),
        .s_ready         (s_axis_tready),
        .q_status        (q_status),
        .push            (push),
        .push_job        (push_job)
    );

    utw8_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status)
    );

    utw8_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_job      (head_job),
        .q_status      (q_status),
        .pop           (pop),
        .m_out_byte    (m_axis_tdata),
        .m_last_of_run (m_axis_tlast),
        .m_valid       (m_axis_tvalid),
        .m_ready       (m_axis_tready)
    );

    // tracks whether the next output byte opens a run
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_first_reg <= 1'b1;
        end else if (m_axis_tvalid && m_axis_tready) begin
            out_first_reg <= m_axis_tlast;
        end
    end

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("output run broken before its last byte");

    a_lead_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && out_first_reg |-> m_axis_tdata[7:6] != 2'b10)
        else $error("run opens with a continuation byte");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("waiting output transaction changed");

    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.full |-> !s_axis_tready)
        else $error("input taken while job queue is full");

endmodule
